/* rtl/core/aigdd_pkg.sv */
// Shared types and constants for the AIGER AND-section delta decoder.
// Used by the front, queue, back and top-level files; no dependencies.
package aigdd_pkg;

  localparam int VAR_BITS = 20;
  localparam int CFG_W    = 20;
  localparam int LIT_W    = 21;
  localparam int DELTA_W  = 32;
  localparam int POS_W    = 3;
  localparam int CIDX_W   = 2;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  // largest legal variable index
  localparam logic [DELTA_W-1:0] VAR_MAX = DELTA_W'((64'd1 << VAR_BITS) - 64'd1);

  localparam logic [POS_W-1:0] MAX_BYTES = POS_W'(5);

  typedef enum logic [CIDX_W-1:0] {
    REG_INPUT_COUNT = 2'd0,
    REG_GATE_COUNT  = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDEFINED = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // one queue entry: a finished delta pair or an error found in the front
  typedef struct packed {
    logic                is_err;
    status_t             status;
    logic                last;
    logic [CFG_W-1:0]    index;
    logic [DELTA_W-1:0]  d0;
    logic [DELTA_W-1:0]  d1;
  } pair_t;

endpackage

/* rtl/core/aigdd_front.sv */
// Front end: takes section bytes, assembles varints, pairs the deltas and
// raises stream errors. Depends on aigdd_pkg.
module aigdd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic                         s_tlast,   // stream_end
  input  logic [aigdd_pkg::CFG_W-1:0]  gate_count,
  input  logic                         q_full,
  output logic                         push,
  output aigdd_pkg::pair_t             push_data
);
  import aigdd_pkg::*;

  logic [DELTA_W-1:0] accum, accum_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic               phase, phase_next;
  logic [DELTA_W-1:0] held, held_next;
  logic [CFG_W-1:0]   pairs, pairs_next;
  logic               halted, halted_next;

  logic               beat;
  logic [DELTA_W-1:0] ins;
  logic [DELTA_W-1:0] merged;
  logic [CFG_W-1:0]   pairs_inc;

  assign s_tready  = !q_full;
  assign beat      = s_tvalid && s_tready;
  assign pairs_inc = pairs + CFG_W'(1);
  assign merged    = accum | ins;

  // place the 7 payload bits of this byte; bits above 31 drop off
  always_comb begin
    case (pos)
      3'd0:    ins = {25'b0, s_tdata[6:0]};
      3'd1:    ins = {18'b0, s_tdata[6:0], 7'b0};
      3'd2:    ins = {11'b0, s_tdata[6:0], 14'b0};
      3'd3:    ins = {4'b0, s_tdata[6:0], 21'b0};
      3'd4:    ins = {s_tdata[3:0], 28'b0};
      default: ins = '0;
    endcase
  end

  always_comb begin
    accum_next  = accum;
    pos_next    = pos;
    phase_next  = phase;
    held_next   = held;
    pairs_next  = pairs;
    halted_next = halted;
    push        = 1'b0;
    push_data   = '{is_err: 1'b0, status: ST_OK, last: 1'b0, index: pairs,
                    d0: held, d1: merged};
    if (beat && !halted && (pairs < gate_count)) begin
      if (s_tlast) begin
        push             = 1'b1;
        push_data.is_err = 1'b1;
        push_data.status = ST_TRUNCATED;
        halted_next      = 1'b1;
      end else if (s_tdata[7]) begin
        pos_next   = pos + POS_W'(1);
        accum_next = merged;
        if (pos_next >= MAX_BYTES) begin
          push             = 1'b1;
          push_data.is_err = 1'b1;
          push_data.status = ST_TOO_LONG;
          halted_next      = 1'b1;
        end
      end else begin
        accum_next = '0;
        pos_next   = '0;
        if (!phase) begin
          held_next  = merged;
          phase_next = 1'b1;
        end else begin
          phase_next     = 1'b0;
          push           = 1'b1;
          push_data.last = (pairs_inc >= gate_count);
          pairs_next     = pairs_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum  <= '0;
      pos    <= '0;
      phase  <= 1'b0;
      held   <= '0;
      pairs  <= '0;
      halted <= 1'b0;
    end else begin
      accum  <= accum_next;
      pos    <= pos_next;
      phase  <= phase_next;
      held   <= held_next;
      pairs  <= pairs_next;
      halted <= halted_next;
    end
  end

endmodule

/* rtl/core/aigdd_queue.sv */
// Small register FIFO of delta pairs between front and back.
// Depends on aigdd_pkg.
module aigdd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aigdd_pkg::pair_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output aigdd_pkg::pair_t  q_data
);
  import aigdd_pkg::*;

  pair_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* rtl/core/aigdd_back.sv */
// Back end: turns delta pairs into gate literals, checks them and holds the
// result beat in an output register. Depends on aigdd_pkg.
module aigdd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [aigdd_pkg::CFG_W-1:0]  input_count,
  input  logic                         q_valid,
  input  aigdd_pkg::pair_t             q_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [63:0]                  m_tdata,   // gate_lit, first_fanin, second_fanin
  output logic                         m_tlast,   // final_gate
  output logic [2:0]                   m_tuser    // status
);
  import aigdd_pkg::*;

  logic              halted;
  logic [LIT_W-1:0]  gate_lit, first_fanin, second_fanin;
  logic              final_gate;
  status_t           status;

  logic [LIT_W-1:0]   var_idx;
  logic [LIT_W:0]     lhs, rhs0, rhs1;
  logic               too_wide, d0_big, d1_big, d0_zero;
  status_t            st_c;
  logic               load;

  assign pop  = q_valid && (!m_tvalid || m_tready);
  assign load = pop && !halted;

  assign var_idx  = LIT_W'(input_count) + LIT_W'(1) + LIT_W'(q_data.index);
  assign too_wide = {{(DELTA_W-LIT_W){1'b0}}, var_idx} > VAR_MAX;
  assign lhs      = {var_idx, 1'b0};
  assign d0_big   = q_data.d0 > {{(DELTA_W-LIT_W-1){1'b0}}, lhs};
  assign rhs0     = lhs - q_data.d0[LIT_W:0];
  assign d1_big   = q_data.d1 > {{(DELTA_W-LIT_W-1){1'b0}}, rhs0};
  assign rhs1     = rhs0 - q_data.d1[LIT_W:0];
  assign d0_zero  = (q_data.d0 == '0);

  always_comb begin
    if (q_data.is_err)                   st_c = q_data.status;
    else if (too_wide || d0_big || d1_big) st_c = ST_OVERFLOW;
    else if (d0_zero)                    st_c = ST_UNDEFINED;
    else                                 st_c = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      halted   <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        if (st_c != ST_OK) halted <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= st_c;
      if (st_c == ST_OK) begin
        gate_lit     <= lhs[LIT_W-1:0];
        first_fanin  <= rhs0[LIT_W-1:0];
        second_fanin <= rhs1[LIT_W-1:0];
        final_gate   <= q_data.last;
      end else begin
        gate_lit     <= '0;
        first_fanin  <= '0;
        second_fanin <= '0;
        final_gate   <= 1'b1;
      end
    end
  end

  assign m_tdata = {1'b0, second_fanin, first_fanin, gate_lit};
  assign m_tlast = final_gate;
  assign m_tuser = status;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |->
      (gate_lit == '0 && first_fanin == '0 && second_fanin == '0 && final_gate))
    else $error("error beat with nonzero literals");
  a_ok_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_OK) |->
      (first_fanin <= gate_lit && second_fanin <= first_fanin && first_fanin != gate_lit))
    else $error("fanin ordering broken");
  a_ok_even: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_OK) |-> !gate_lit[0])
    else $error("odd gate literal");
`endif

endmodule

/* rtl/core/aiger_and_delta_decoder_unit.sv */
// Top level of the AIGER AND-section delta decoder: config registers,
// front, pair queue and back. Depends on aigdd_pkg and the aigdd_* modules.
//
//  port group  dir  beat content
//  s_*         in   tdata[7:0] data_byte, tlast stream_end
//  m_*         out  tdata gate_lit/first_fanin/second_fanin, tlast final_gate, tuser status
//  cfg_*       in   cfg_index register number, cfg_data value
//
// One byte per cycle while s_tready is high; a gate result passes the pair queue, then the output register.
// The 4-entry pair queue plus the output register absorb output stalls;
// s_tready drops only when the queue is full.
// Reset (rst, synchronous) clears all control state; config writes always ready.
module aiger_and_delta_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // stream_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // [20:0] gate_lit, [41:21] first_fanin,
                                                   // [62:42] second_fanin, [63] zero
  output logic                          m_tlast,   // final_gate
  output logic [2:0]                    m_tuser,   // [2:0] status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aigdd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [aigdd_pkg::CFG_W-1:0]   cfg_data
);
  import aigdd_pkg::*;

  logic [CFG_W-1:0] input_count, gate_count;
  logic             push, full, pop, q_valid;
  pair_t            push_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count <= '0;
      gate_count  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INPUT_COUNT: input_count <= cfg_data;
        REG_GATE_COUNT:  gate_count  <= cfg_data;
        default:         ;
      endcase
    end
  end

  aigdd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .gate_count (gate_count),
    .q_full     (full),
    .push       (push),
    .push_data  (push_data)
  );

  aigdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  aigdd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .input_count (input_count),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

/* sim/aiger_and_delta_decoder_unit_tb.sv */
// Self-checking testbench for aiger_and_delta_decoder_unit: byte stream in, gate beats out.
// A directed table runs first, then random sections under several stall patterns, then one injected error.
// Depends on aigdd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module aiger_and_delta_decoder_unit_tb;
  import aigdd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_BYTES  = 1350;
  localparam int SND_IDLE[4]   = '{0, 82, 0, 16};
  localparam int RCV_STALL[4]  = '{0, 0, 82, 16};

  // indexes the block has no register for
  localparam logic [CIDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [CFG_W-1:0]  CFG_MAX     = '1;

  typedef struct packed {
    logic [LIT_W-1:0] gate_lit;
    logic [LIT_W-1:0] first_fanin;
    logic [LIT_W-1:0] second_fanin;
    logic             final_gate;
    status_t          status;
  } gate_result_t;

  typedef enum int {ROW_RAW, ROW_CFG, ROW_GATE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CIDX_W-1:0] idx;
    logic [31:0]       a;
    logic [31:0]       b;
    int                nb;
    bit                chk;
    gate_result_t      want;
  } plan_row_t;

  typedef enum int {
    FAULT_TOO_LONG, FAULT_D0_BIG, FAULT_D1_BIG, FAULT_WIDE_VAR,
    FAULT_ZERO_D0, FAULT_END_MID, FAULT_END_GAP
  } fault_kind_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;   // [7:0] data_byte
  logic              s_tlast   = 1'b0; // stream_end
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [63:0]       m_tdata;          // [20:0] gate_lit, [41:21] first_fanin,
                                       // [62:42] second_fanin, [63] zero
  logic              m_tlast;          // final_gate
  logic [2:0]        m_tuser;          // [2:0] status
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  aiger_and_delta_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder state mirrored on the bench side
  logic [CFG_W-1:0]   dec_input_count = '0;
  logic [CFG_W-1:0]   dec_gate_count  = '0;
  logic [DELTA_W-1:0] dec_accum       = '0;
  logic [POS_W-1:0]   dec_pos         = '0;
  logic               dec_second      = 1'b0;
  logic [DELTA_W-1:0] dec_d0          = '0;
  logic [CFG_W-1:0]   dec_done        = '0;
  logic               dec_halted      = 1'b0;

  gate_result_t pending_gates[$];
  gate_result_t typed_want;
  bit           use_typed     = 1'b0;
  int           fail_count    = 0;
  int           live_bytes    = 0;
  int           snd_idle_pct  = 0;
  int           rcv_stall_pct = 0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;
  int           cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic gate_result_t halt_with(status_t st);
    gate_result_t r;
    r            = '0;
    r.final_gate = 1'b1;
    r.status     = st;
    dec_halted   = 1'b1;
    return r;
  endfunction

  // Advances the mirrored state by one accepted byte; returns 1 when a gate beat is due.
  function automatic bit decode_step(input logic [7:0] b, input logic eos,
                                     output gate_result_t r);
    logic [DELTA_W-1:0] value;
    logic [63:0]        var_idx;
    logic [63:0]        lhs;
    logic [63:0]        rhs0;
    r = '0;
    if (dec_halted || dec_done >= dec_gate_count) return 1'b0;
    if (eos) begin
      r = halt_with(ST_TRUNCATED);
      return 1'b1;
    end
    dec_accum = dec_accum | (DELTA_W'(b[6:0]) << (7 * dec_pos));
    if (b[7]) begin
      dec_pos = dec_pos + 1'b1;
      if (dec_pos >= MAX_BYTES) begin
        r = halt_with(ST_TOO_LONG);
        return 1'b1;
      end
      return 1'b0;
    end
    value     = dec_accum;
    dec_accum = '0;
    dec_pos   = '0;
    if (!dec_second) begin
      dec_d0     = value;
      dec_second = 1'b1;
      return 1'b0;
    end
    dec_second = 1'b0;
    // range checks in fixed order: variable, first delta, second delta, zero fanin
    var_idx = 64'(dec_input_count) + 64'd1 + 64'(dec_done);
    lhs     = var_idx << 1;
    rhs0    = lhs - 64'(dec_d0);
    if (var_idx > 64'(VAR_MAX) || 64'(dec_d0) > lhs || 64'(value) > rhs0) begin
      r = halt_with(ST_OVERFLOW);
    end else if (dec_d0 == '0) begin
      r = halt_with(ST_UNDEFINED);
    end else begin
      dec_done       = dec_done + 1'b1;
      r.gate_lit     = lhs[LIT_W-1:0];
      r.first_fanin  = rhs0[LIT_W-1:0];
      r.second_fanin = LIT_W'(rhs0 - 64'(value));
      r.final_gate   = (dec_done >= dec_gate_count);
      r.status       = ST_OK;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] current_lhs();
    return (32'(dec_input_count) + 32'd1 + 32'(dec_done)) << 1;
  endfunction

  // mostly small values, with both ends of the range now and then
  function automatic logic [31:0] pick_skewed(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] span;
    span = hi - lo;
    case ($urandom_range(9))
      0:       return hi;
      1:       return lo;
      2, 3:    return $urandom_range(hi, lo);
      default: return lo + $urandom_range((span > 63) ? 63 : span, 0);
    endcase
  endfunction

  function automatic plan_row_t raw_row(logic [7:0] b, logic eos);
    plan_row_t row;
    row      = '{kind: ROW_RAW, default: '0};
    row.a    = 32'(b);
    row.b    = 32'(eos);
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t row;
    row      = '{kind: ROW_CFG, default: '0};
    row.idx  = idx;
    row.a    = 32'(val);
    return row;
  endfunction

  function automatic plan_row_t gate_row(int d0, int d1, int nb, bit chk,
                                         int g, int f0, int f1, bit fin);
    plan_row_t row;
    row                   = '{kind: ROW_GATE, default: '0};
    row.a                 = d0;
    row.b                 = d1;
    row.nb                = nb;
    row.chk               = chk;
    row.want.gate_lit     = LIT_W'(g);
    row.want.first_fanin  = LIT_W'(f0);
    row.want.second_fanin = LIT_W'(f1);
    row.want.final_gate   = fin;
    row.want.status       = ST_OK;
    return row;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    gate_result_t r;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    if (!dec_halted && dec_done < dec_gate_count) live_bytes++;
    if (decode_step(b, eos, r)) pending_gates = {pending_gates, (use_typed ? typed_want : r)};
  endtask

  // nb above the minimal length pads with zero groups; a fifth byte carries junk in
  // bits 6:4, which fall above bit 31 and are dropped
  task automatic send_varint(input logic [31:0] v, input int nb);
    int         len;
    logic [7:0] b;
    len = 1;
    while (len < 5 && (v >> (7 * len)) != 0) len++;
    if (nb > len) len = nb;
    for (int i = 0; i < len; i++) begin
      if (i < 4) b = {1'b0, v[7*i +: 7]};
      else       b = {1'b0, 3'($urandom), v[31:28]};
      b[7] = (i != len - 1);
      send_byte(b, 1'b0);
    end
  endtask

  task automatic random_gate();
    logic [31:0] lhs;
    logic [31:0] d0;
    logic [31:0] d1;
    int          nb;
    lhs = current_lhs();
    d0  = pick_skewed(32'd1, lhs);
    d1  = pick_skewed(32'd0, lhs - d0);
    nb  = ($urandom_range(6) == 0) ? $urandom_range(5, 1) : 0;
    send_varint(d0, nb);
    send_varint(d1, nb);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_INPUT_COUNT)     dec_input_count = val;
    else if (idx == REG_GATE_COUNT) dec_gate_count  = val;
    @(posedge clk);
  endtask

  // stop offering, wait out every pending gate beat, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_gates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_gate();
    gate_result_t want;
    if (pending_gates.size() == 0) begin
      note_mismatch("gate beat with nothing pending");
      return;
    end
    want = pending_gates.pop_front();
    if (m_tdata[20:0] !== want.gate_lit)
      note_mismatch($sformatf("gate_lit %0d, want %0d", m_tdata[20:0], want.gate_lit));
    if (m_tdata[41:21] !== want.first_fanin)
      note_mismatch($sformatf("first_fanin %0d, want %0d", m_tdata[41:21],
                              want.first_fanin));
    if (m_tdata[62:42] !== want.second_fanin)
      note_mismatch($sformatf("second_fanin %0d, want %0d", m_tdata[62:42],
                              want.second_fanin));
    if (m_tlast !== want.final_gate)
      note_mismatch($sformatf("final_gate %b, want %b", m_tlast, want.final_gate));
    if (m_tuser !== want.status)
      note_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
  endtask

  // receive side: check accepted beats, then pick next tready
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_gate();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    plan_row_t   plan[$];
    int          phase;
    int          n_gates;
    int          max_ic;
    int          start_bytes;
    fault_kind_t fault;
    logic [31:0] lhs;
    logic [31:0] d0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gate_count is 0 out of reset, so these are dropped
    plan = {plan, raw_row(8'h85, 1'b0)};
    plan = {plan, raw_row(8'h00, 1'b1)};
    plan = {plan, cfg_row(REG_INPUT_COUNT, 20'd0)};
    plan = {plan, cfg_row(REG_GATE_COUNT, 20'd5)};
    plan = {plan, gate_row(2, 0, 0, 1, 2, 0, 0, 0)};
    plan = {plan, gate_row(1, 3, 5, 1, 4, 3, 0, 0)};
    plan = {plan, gate_row(6, 0, 2, 1, 6, 0, 0, 0)};
    plan = {plan, gate_row(5, 2, 4, 0, 0, 0, 0, 0)};
    plan = {plan, gate_row(1, 9, 0, 1, 10, 9, 0, 1)};
    // section complete: bytes and stream end dropped
    plan = {plan, raw_row(8'hFF, 1'b0)};
    plan = {plan, raw_row(8'h00, 1'b1)};
    plan = {plan, cfg_row(REG_GATE_COUNT, 20'd2)};
    plan = {plan, raw_row(8'h7F, 1'b0)};
    plan = {plan, cfg_row(REG_INPUT_COUNT, CFG_MAX)};
    plan = {plan, raw_row(8'h55, 1'b1)};
    plan = {plan, cfg_row(REG_SPARE_2, CFG_MAX)};
    plan = {plan, cfg_row(REG_SPARE_3, 20'd1)};
    // last two variables of the legal range
    plan = {plan, cfg_row(REG_INPUT_COUNT, CFG_W'(int'(VAR_MAX) - 7))};
    plan = {plan, cfg_row(REG_GATE_COUNT, 20'd7)};
    plan = {plan, gate_row(2097148, 0, 0, 1, 2097148, 0, 0, 0)};
    plan = {plan, gate_row(1, 2097149, 0, 1, 2097150, 2097149, 0, 1)};

    snd_idle_pct  = 16;
    rcv_stall_pct = 16;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_RAW: send_byte(plan[i].a[7:0], plan[i].b[0]);
        ROW_CFG: begin
          settle();
          write_reg(plan[i].idx, plan[i].a[CFG_W-1:0]);
        end
        default: begin
          use_typed  = plan[i].chk;
          typed_want = plan[i].want;
          send_varint(plan[i].a, plan[i].nb);
          send_varint(plan[i].b, plan[i].nb);
          use_typed  = 1'b0;
        end
      endcase
    end
    settle();

    start_bytes = live_bytes;
    phase       = 0;
    while (live_bytes - start_bytes < RANDOM_BYTES) begin
      snd_idle_pct  = SND_IDLE[phase % 4];
      rcv_stall_pct = RCV_STALL[phase % 4];
      n_gates = $urandom_range(45, 15);
      max_ic  = int'(VAR_MAX) - 1 - int'(dec_done) - n_gates;
      case ($urandom_range(3))
        0:       max_ic = 0;
        1:       ;
        default: max_ic = $urandom_range(max_ic, 0);
      endcase
      if ($urandom_range(1)) begin
        write_reg(REG_INPUT_COUNT, CFG_W'(max_ic));
        write_reg(REG_GATE_COUNT, CFG_W'(int'(dec_done) + n_gates));
      end else begin
        write_reg(REG_GATE_COUNT, CFG_W'(int'(dec_done) + n_gates));
        write_reg(REG_INPUT_COUNT, CFG_W'(max_ic));
      end
      // long output hold-off while bytes keep coming: fills the pair queue
      if (phase == 0) hold_req = 1'b1;
      for (int k = 0; k < n_gates; k++) begin
        if (phase == 1 && k == n_gates / 2) settle();
        random_gate();
      end
      repeat ($urandom_range(4)) send_byte(8'($urandom), 1'($urandom));
      settle();
      if ($urandom_range(3) == 0) begin
        write_reg(REG_GATE_COUNT, CFG_W'($urandom_range(int'(dec_done), 0)));
        repeat (3) send_byte(8'($urandom), 1'($urandom));
        settle();
      end
      phase++;
    end

    // errors stick until reset, and reset is applied once, so only one per run
    fault         = fault_kind_t'($urandom_range(6));
    snd_idle_pct  = 16;
    rcv_stall_pct = 16;
    write_reg(REG_INPUT_COUNT,
              (fault == FAULT_WIDE_VAR) ? CFG_MAX : CFG_W'($urandom_range(1000)));
    write_reg(REG_GATE_COUNT, CFG_MAX);
    if (fault != FAULT_WIDE_VAR) repeat ($urandom_range(5, 2)) random_gate();
    lhs = current_lhs();
    d0  = pick_skewed(32'd1, lhs);
    case (fault)
      FAULT_TOO_LONG: begin
        if ($urandom_range(1)) send_varint(d0, 0);
        repeat (5) send_byte({1'b1, 7'($urandom)}, 1'b0);
      end
      FAULT_D0_BIG: begin
        send_varint(pick_skewed(lhs + 32'd1, 32'hFFFF_FFFF), 0);
        send_varint($urandom, 0);
      end
      FAULT_D1_BIG: begin
        send_varint(d0, 0);
        send_varint(pick_skewed(lhs - d0 + 32'd1, 32'hFFFF_FFFF), 0);
      end
      FAULT_WIDE_VAR: begin
        send_varint(d0, 0);
        send_varint(pick_skewed(32'd0, lhs - d0), 0);
      end
      FAULT_ZERO_D0: begin
        send_varint(32'd0, 0);
        send_varint(pick_skewed(32'd0, lhs), 0);
      end
      FAULT_END_MID: begin
        if ($urandom_range(1)) send_varint(d0, 0);
        repeat ($urandom_range(4, 1)) send_byte({1'b1, 7'($urandom)}, 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      default: begin
        if ($urandom_range(1)) send_varint(d0, 0);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
    // halted from here on: all of this is dropped
    repeat (12) send_byte(8'($urandom), 1'($urandom));
    settle();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
